### rtl/prtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prtu_pkg;

    // Input actions. Codes six and seven carry no meaning and change nothing.
    typedef enum logic [2:0] {
        ACT_TICK         = 3'd0,
        ACT_DRANK        = 3'd1,
        ACT_WATER_SNOOZE = 3'd2,
        ACT_STOOD        = 3'd3,
        ACT_SIT_SNOOZE   = 3'd4,
        ACT_NEW_DAY      = 3'd5
    } t_action;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ABSENT_DEBOUNCE  = 3'd0,
        CFG_WATER_FIRST      = 3'd1,
        CFG_WATER_HOT        = 3'd2,
        CFG_HOT_THRESHOLD    = 3'd3,
        CFG_WATER_SNOOZE     = 3'd4,
        CFG_SIT_FIRST        = 3'd5,
        CFG_SIT_SECOND       = 3'd6,
        CFG_SIT_LATER        = 3'd7
    } t_cfg_index;

    localparam logic [1:0] PRES_NEAR = 2'd0;
    localparam logic [1:0] PRES_AWAY = 2'd1;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    localparam logic [7:0] STAND_AWAY_SECONDS = 8'd3;
    localparam logic [7:0] DRINK_MILESTONE    = 8'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic        [7:0]  absent_debounce;
        logic        [15:0] water_first_seconds;
        logic        [15:0] water_hot_seconds;
        logic signed [7:0]  hot_threshold;
        logic        [15:0] water_snooze_seconds;
        logic        [15:0] sit_first_seconds;
        logic        [15:0] sit_second_seconds;
        logic        [15:0] sit_later_seconds;
    } t_cfg;

    typedef struct packed {
        logic        [2:0] action;
        logic        [1:0] presence;
        logic signed [7:0] temperature;
    } t_item;

    typedef struct packed {
        logic        seated;
        logic [1:0]  presence_event;
        logic [3:0]  water_popup;
        logic [3:0]  sit_popup;
        logic        close_water;
        logic        close_sit;
        logic        water_milestone;
        logic [15:0] water_left;
        logic [15:0] sit_left;
        logic [7:0]  drinks_today;
        logic [7:0]  stands_today;
        logic [7:0]  declines;
    } t_result;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [3:0] sat_inc4(input logic [3:0] v);
        return (v == 4'hF) ? v : v + 4'd1;
    endfunction

endpackage

`default_nettype wire

### rtl/prtu_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface prtu_in_if;
    logic              valid;
    logic              ready;
    logic        [2:0] action;
    logic        [1:0] presence;
    logic signed [7:0] temperature;

    modport source (output valid, action, presence, temperature, input ready);
    modport sink   (input valid, action, presence, temperature, output ready);
endinterface

// Result item channel.
interface prtu_out_if;
    logic        valid;
    logic        ready;
    logic        seated;
    logic [1:0]  presence_event;
    logic [3:0]  water_popup;
    logic [3:0]  sit_popup;
    logic        close_water;
    logic        close_sit;
    logic        water_milestone;
    logic [15:0] water_left;
    logic [15:0] sit_left;
    logic [7:0]  drinks_today;
    logic [7:0]  stands_today;
    logic [7:0]  declines;

    modport source (output valid, seated, presence_event, water_popup, sit_popup,
                    close_water, close_sit, water_milestone, water_left, sit_left,
                    drinks_today, stands_today, declines, input ready);
    modport sink   (input valid, seated, presence_event, water_popup, sit_popup,
                    close_water, close_sit, water_milestone, water_left, sit_left,
                    drinks_today, stands_today, declines, output ready);
endinterface

// Configuration write channel.
interface prtu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/prtu_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

// Configuration register file; every write is taken at once.
module prtu_cfg (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_wr_en,
    input  wire [prtu_pkg::CFG_INDEX_W-1:0]   i_wr_index,
    input  wire [prtu_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output prtu_pkg::t_cfg                    o_cfg
);

    prtu_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.absent_debounce      <= 8'd30;
            r_cfg.water_first_seconds  <= 16'd2700;
            r_cfg.water_hot_seconds    <= 16'd1800;
            r_cfg.hot_threshold        <= 8'sd30;
            r_cfg.water_snooze_seconds <= 16'd900;
            r_cfg.sit_first_seconds    <= 16'd1800;
            r_cfg.sit_second_seconds   <= 16'd3600;
            r_cfg.sit_later_seconds    <= 16'd5400;
        end else if (i_wr_en) begin
            case (prtu_pkg::t_cfg_index'(i_wr_index))
                prtu_pkg::CFG_ABSENT_DEBOUNCE: r_cfg.absent_debounce <= i_wr_data[7:0];
                prtu_pkg::CFG_WATER_FIRST:     r_cfg.water_first_seconds <= i_wr_data;
                prtu_pkg::CFG_WATER_HOT:       r_cfg.water_hot_seconds <= i_wr_data;
                prtu_pkg::CFG_HOT_THRESHOLD:   r_cfg.hot_threshold <= $signed(i_wr_data[7:0]);
                prtu_pkg::CFG_WATER_SNOOZE:    r_cfg.water_snooze_seconds <= i_wr_data;
                prtu_pkg::CFG_SIT_FIRST:       r_cfg.sit_first_seconds <= i_wr_data;
                prtu_pkg::CFG_SIT_SECOND:      r_cfg.sit_second_seconds <= i_wr_data;
                prtu_pkg::CFG_SIT_LATER:       r_cfg.sit_later_seconds <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/prtu_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Session and countdown state, updated once for each item that is stepped.
module prtu_core #(
    parameter int SEAT_DEBOUNCE = 5
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_step,
    input  prtu_pkg::t_item   i_item,
    input  prtu_pkg::t_cfg    i_cfg,
    output prtu_pkg::t_result o_result
);

    localparam logic [7:0] SEAT_LIMIT = 8'(SEAT_DEBOUNCE);

    logic        r_seated,      n_seated;
    logic [7:0]  r_seat_ticks,  n_seat_ticks;
    logic [7:0]  r_away_ticks,  n_away_ticks;
    logic        r_leaving,     n_leaving;
    logic        r_stand_noted, n_stand_noted;
    logic [7:0]  r_away_secs,   n_away_secs;
    logic [15:0] r_water_rem,   n_water_rem;
    logic [3:0]  r_water_stage, n_water_stage;
    logic [15:0] r_sit_rem,     n_sit_rem;
    logic [3:0]  r_sit_stage,   n_sit_stage;
    logic [7:0]  r_drinks,      n_drinks;
    logic [7:0]  r_stands,      n_stands;
    logic [7:0]  r_declines,    n_declines;

    logic        hot;
    logic [15:0] water_interval;

    assign hot            = (i_item.temperature >= i_cfg.hot_threshold);
    assign water_interval = hot ? i_cfg.water_hot_seconds : i_cfg.water_first_seconds;

    always_comb begin
        n_seated      = r_seated;
        n_seat_ticks  = r_seat_ticks;
        n_away_ticks  = r_away_ticks;
        n_leaving     = r_leaving;
        n_stand_noted = r_stand_noted;
        n_away_secs   = r_away_secs;
        n_water_rem   = r_water_rem;
        n_water_stage = r_water_stage;
        n_sit_rem     = r_sit_rem;
        n_sit_stage   = r_sit_stage;
        n_drinks      = r_drinks;
        n_stands      = r_stands;
        n_declines    = r_declines;
        o_result      = '0;

        case (prtu_pkg::t_action'(i_item.action))
            prtu_pkg::ACT_TICK: begin
                if (i_item.presence == prtu_pkg::PRES_NEAR) begin
                    n_away_ticks  = '0;
                    n_leaving     = 1'b0;
                    n_stand_noted = 1'b0;
                    if (!r_seated) begin
                        n_seat_ticks = prtu_pkg::sat_inc8(r_seat_ticks);
                        if (n_seat_ticks >= SEAT_LIMIT) begin
                            n_seat_ticks = '0;
                            n_seated     = 1'b1;
                            n_away_secs  = '0;
                            if (r_water_rem == 16'd0) begin
                                n_water_stage = '0;
                                n_water_rem   = water_interval;
                            end
                            n_sit_stage = '0;
                            n_sit_rem   = i_cfg.sit_first_seconds;
                            o_result.presence_event = prtu_pkg::EV_START;
                        end
                    end
                end else if (i_item.presence == prtu_pkg::PRES_AWAY) begin
                    n_seat_ticks = '0;
                    if (r_seated) begin
                        n_leaving   = 1'b1;
                        n_away_secs = prtu_pkg::sat_inc8(r_away_secs);
                        if (!r_stand_noted && n_away_secs >= prtu_pkg::STAND_AWAY_SECONDS) begin
                            n_stand_noted = 1'b1;
                            n_stands      = prtu_pkg::sat_inc8(r_stands);
                        end
                        n_away_ticks = prtu_pkg::sat_inc8(r_away_ticks);
                        if (n_away_ticks >= i_cfg.absent_debounce) begin
                            n_away_ticks = '0;
                            n_seated     = 1'b0;
                            n_leaving    = 1'b0;
                            n_sit_stage  = '0;
                            n_sit_rem    = '0;
                            o_result.presence_event = prtu_pkg::EV_END;
                            o_result.close_water    = 1'b1;
                            o_result.close_sit      = 1'b1;
                        end
                    end
                end
                // Countdowns run on the state left by the presence update above.
                if (n_seated && !n_leaving) begin
                    if (n_water_rem != 16'd0) begin
                        n_water_rem = n_water_rem - 16'd1;
                        if (n_water_rem == 16'd0) begin
                            n_water_stage        = prtu_pkg::sat_inc4(n_water_stage);
                            o_result.water_popup = n_water_stage;
                        end
                    end
                    if (n_sit_rem != 16'd0) begin
                        n_sit_rem = n_sit_rem - 16'd1;
                        if (n_sit_rem == 16'd0) begin
                            n_sit_stage        = prtu_pkg::sat_inc4(n_sit_stage);
                            o_result.sit_popup = n_sit_stage;
                        end
                    end
                end
            end
            prtu_pkg::ACT_DRANK: begin
                n_drinks      = prtu_pkg::sat_inc8(r_drinks);
                n_declines    = '0;
                n_water_stage = '0;
                n_water_rem   = water_interval;
                o_result.water_milestone = (n_drinks == prtu_pkg::DRINK_MILESTONE);
                o_result.close_water     = 1'b1;
            end
            prtu_pkg::ACT_WATER_SNOOZE: begin
                n_declines = prtu_pkg::sat_inc8(r_declines);
                if (r_water_stage != 4'd0 && r_water_rem == 16'd0) begin
                    n_water_rem = i_cfg.water_snooze_seconds;
                end
                o_result.close_water = 1'b1;
            end
            prtu_pkg::ACT_STOOD: begin
                n_stands      = prtu_pkg::sat_inc8(r_stands);
                n_declines    = '0;
                n_sit_stage   = '0;
                n_sit_rem     = i_cfg.sit_first_seconds;
                n_water_stage = '0;
                n_water_rem   = water_interval;
                o_result.close_water = 1'b1;
                o_result.close_sit   = 1'b1;
            end
            prtu_pkg::ACT_SIT_SNOOZE: begin
                n_declines = prtu_pkg::sat_inc8(r_declines);
                if (r_sit_stage != 4'd0 && r_sit_rem == 16'd0) begin
                    n_sit_rem = (r_sit_stage == 4'd1) ? i_cfg.sit_second_seconds
                                                      : i_cfg.sit_later_seconds;
                end
                o_result.close_sit = 1'b1;
            end
            prtu_pkg::ACT_NEW_DAY: begin
                n_drinks   = '0;
                n_stands   = '0;
                n_declines = '0;
            end
            default: ;
        endcase

        o_result.seated       = n_seated;
        o_result.water_left   = n_water_rem;
        o_result.sit_left     = n_sit_rem;
        o_result.drinks_today = n_drinks;
        o_result.stands_today = n_stands;
        o_result.declines     = n_declines;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seated      <= 1'b0;
            r_seat_ticks  <= '0;
            r_away_ticks  <= '0;
            r_leaving     <= 1'b0;
            r_stand_noted <= 1'b0;
            r_away_secs   <= '0;
            r_water_rem   <= '0;
            r_water_stage <= '0;
            r_sit_rem     <= '0;
            r_sit_stage   <= '0;
            r_drinks      <= '0;
            r_stands      <= '0;
            r_declines    <= '0;
        end else if (i_step) begin
            r_seated      <= n_seated;
            r_seat_ticks  <= n_seat_ticks;
            r_away_ticks  <= n_away_ticks;
            r_leaving     <= n_leaving;
            r_stand_noted <= n_stand_noted;
            r_away_secs   <= n_away_secs;
            r_water_rem   <= n_water_rem;
            r_water_stage <= n_water_stage;
            r_sit_rem     <= n_sit_rem;
            r_sit_stage   <= n_sit_stage;
            r_drinks      <= n_drinks;
            r_stands      <= n_stands;
            r_declines    <= n_declines;
        end
    end

    a_leaving_needs_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leaving |-> r_seated)
        else $error("leaving flag set outside a seated session");

    a_start_is_seated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.presence_event == prtu_pkg::EV_START) |-> o_result.seated)
        else $error("session start reported without a session");

    a_end_clears_sit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.presence_event == prtu_pkg::EV_END)
        |-> (!o_result.seated && o_result.sit_left == 16'd0 && o_result.close_sit))
        else $error("session end left the sit timer running");

    a_popup_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.water_popup != 4'd0) |-> (o_result.water_left == 16'd0))
        else $error("water popup raised with time still left");

    a_popup_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.action != prtu_pkg::ACT_TICK)
        |-> (o_result.water_popup == 4'd0 && o_result.sit_popup == 4'd0))
        else $error("popup raised by a button action");

endmodule

`default_nettype wire

### rtl/presence_reminder_timer_unit.sv
// Each item goes through the input register, then its result waits in the result
// register until the sink completes the output transaction. Throughput: one item
// per cycle unless the result stalls; the session and countdown state is updated
// in a single short pass, so each item sees the state left by the one before it.
// Reset (i_rst_n, synchronous, active low) clears all state and both stages and
// loads the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module presence_reminder_timer_unit #(
    parameter int SEAT_DEBOUNCE = 5
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    prtu_in_if.sink      i_in,
    prtu_out_if.source   o_out,
    prtu_cfg_if.sink     i_cfg
);

    // Configuration writes are always accepted. The user must issue them only while
    // no item is in flight; the block does not enforce this, having no interlock.
    prtu_pkg::t_cfg cfg;

    assign i_cfg.ready = 1'b1;

    prtu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    // Input register. It is refilled whenever its item moves on to the result
    // stage, so a new transaction can be taken in every cycle even while a result
    // is waiting, as long as the result register will be free at the same edge.
    logic            r_s1_valid;
    prtu_pkg::t_item r_s1_item;
    logic            r_out_valid;
    prtu_pkg::t_result r_out;

    logic            s2_ready;
    logic            step;
    logic            in_fire;
    prtu_pkg::t_result result;

    assign s2_ready   = !r_out_valid || o_out.ready;
    assign step       = r_s1_valid && s2_ready;
    assign i_in.ready = !r_s1_valid || s2_ready;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_fire || (r_s1_valid && !s2_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item.action      <= i_in.action;
            r_s1_item.presence    <= i_in.presence;
            r_s1_item.temperature <= i_in.temperature;
        end
    end

    // The state only advances when the item in the input register is stepped,
    // which is exactly when its result is captured below.
    prtu_core #(
        .SEAT_DEBOUNCE (SEAT_DEBOUNCE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_s1_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register: holds a finished result until the sink completes the
    // output transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.seated          = r_out.seated;
    assign o_out.presence_event  = r_out.presence_event;
    assign o_out.water_popup     = r_out.water_popup;
    assign o_out.sit_popup       = r_out.sit_popup;
    assign o_out.close_water     = r_out.close_water;
    assign o_out.close_sit       = r_out.close_sit;
    assign o_out.water_milestone = r_out.water_milestone;
    assign o_out.water_left      = r_out.water_left;
    assign o_out.sit_left        = r_out.sit_left;
    assign o_out.drinks_today    = r_out.drinks_today;
    assign o_out.stands_today    = r_out.stands_today;
    assign o_out.declines        = r_out.declines;

endmodule

`default_nettype wire

### tb/tb_presence_reminder_timer_unit.sv
`timescale 1ns / 1ps

module tb_presence_reminder_timer_unit;

    // The block is built with this seat debounce, and the bench predicts with it.
    localparam int SEAT_TICKS = 5;

    // Presence codes and action codes that the package does not name.
    localparam logic [1:0] PRES_MISSING = 2'd2;
    localparam logic [1:0] PRES_CODE3   = 2'd3;
    localparam logic [2:0] ACT_SPARE_6  = 3'd6;
    localparam logic [2:0] ACT_SPARE_7  = 3'd7;

    // Reminder predictor: a private copy of the configuration and of the session
    // and countdown state, plus the queue of results that are still to arrive.
    class reminder_scoreboard;
        logic [7:0]        absent_limit;
        logic [15:0]       water_first;
        logic [15:0]       water_hot;
        logic signed [7:0] hot_level;
        logic [15:0]       water_snooze;
        logic [15:0]       sit_first;
        logic [15:0]       sit_second;
        logic [15:0]       sit_later;

        bit          seated;
        bit          leaving;
        bit          stand_noted;
        logic [7:0]  seat_ticks;
        logic [7:0]  away_ticks;
        logic [7:0]  away_secs;
        logic [15:0] water_left;
        logic [3:0]  water_stage;
        logic [15:0] sit_left;
        logic [3:0]  sit_stage;
        logic [7:0]  drinks;
        logic [7:0]  stands;
        logic [7:0]  declines;

        prtu_pkg::t_result expected_results[$];
        int                mismatches;
        int                results_seen;

        function new();
            restore();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void restore();
            absent_limit = 8'd30;
            water_first  = 16'd2700;
            water_hot    = 16'd1800;
            hot_level    = 8'sd30;
            water_snooze = 16'd900;
            sit_first    = 16'd1800;
            sit_second   = 16'd3600;
            sit_later    = 16'd5400;
            seated       = 1'b0;
            leaving      = 1'b0;
            stand_noted  = 1'b0;
            seat_ticks   = '0;
            away_ticks   = '0;
            away_secs    = '0;
            water_left   = '0;
            water_stage  = '0;
            sit_left     = '0;
            sit_stage    = '0;
            drinks       = '0;
            stands       = '0;
            declines     = '0;
        endfunction

        function void write_reg(prtu_pkg::t_cfg_index idx, logic [15:0] v);
            case (idx)
                prtu_pkg::CFG_ABSENT_DEBOUNCE: absent_limit = v[7:0];
                prtu_pkg::CFG_WATER_FIRST:     water_first  = v;
                prtu_pkg::CFG_WATER_HOT:       water_hot    = v;
                prtu_pkg::CFG_HOT_THRESHOLD:   hot_level    = v[7:0];
                prtu_pkg::CFG_WATER_SNOOZE:    water_snooze = v;
                prtu_pkg::CFG_SIT_FIRST:       sit_first    = v;
                prtu_pkg::CFG_SIT_SECOND:      sit_second   = v;
                prtu_pkg::CFG_SIT_LATER:       sit_later    = v;
                default: ;
            endcase
        endfunction

        function logic [7:0] up8(logic [7:0] v);
            return (&v) ? v : v + 8'd1;
        endfunction

        function logic [3:0] up4(logic [3:0] v);
            return (&v) ? v : v + 4'd1;
        endfunction

        function void arm_water(logic signed [7:0] t);
            water_stage = '0;
            water_left  = (t >= hot_level) ? water_hot : water_first;
        endfunction

        function void arm_sit();
            sit_stage = '0;
            sit_left  = sit_first;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Advances the state by one accepted item and queues the result it implies.
        function void note_item(prtu_pkg::t_item it);
            prtu_pkg::t_result r;
            r = '0;
            case (it.action)
                prtu_pkg::ACT_TICK: begin
                    if (it.presence == prtu_pkg::PRES_NEAR) begin
                        away_ticks  = '0;
                        leaving     = 1'b0;
                        stand_noted = 1'b0;
                        if (!seated) begin
                            seat_ticks = up8(seat_ticks);
                            if (seat_ticks >= SEAT_TICKS) begin
                                seat_ticks = '0;
                                seated     = 1'b1;
                                away_secs  = '0;
                                if (water_left == 16'd0)
                                    arm_water(it.temperature);
                                arm_sit();
                                r.presence_event = prtu_pkg::EV_START;
                            end
                        end
                    end else if (it.presence == prtu_pkg::PRES_AWAY) begin
                        seat_ticks = '0;
                        if (seated) begin
                            leaving   = 1'b1;
                            away_secs = up8(away_secs);
                            if (!stand_noted &&
                                away_secs >= prtu_pkg::STAND_AWAY_SECONDS) begin
                                stand_noted = 1'b1;
                                stands      = up8(stands);
                            end
                            away_ticks = up8(away_ticks);
                            if (away_ticks >= absent_limit) begin
                                away_ticks       = '0;
                                seated           = 1'b0;
                                leaving          = 1'b0;
                                sit_stage        = '0;
                                sit_left         = '0;
                                r.presence_event = prtu_pkg::EV_END;
                                r.close_water    = 1'b1;
                                r.close_sit      = 1'b1;
                            end
                        end
                    end
                    if (seated && !leaving) begin
                        if (water_left != 16'd0) begin
                            water_left = water_left - 16'd1;
                            if (water_left == 16'd0) begin
                                water_stage   = up4(water_stage);
                                r.water_popup = water_stage;
                            end
                        end
                        if (sit_left != 16'd0) begin
                            sit_left = sit_left - 16'd1;
                            if (sit_left == 16'd0) begin
                                sit_stage   = up4(sit_stage);
                                r.sit_popup = sit_stage;
                            end
                        end
                    end
                end
                prtu_pkg::ACT_DRANK: begin
                    drinks   = up8(drinks);
                    declines = '0;
                    arm_water(it.temperature);
                    r.water_milestone = (drinks == prtu_pkg::DRINK_MILESTONE);
                    r.close_water     = 1'b1;
                end
                prtu_pkg::ACT_WATER_SNOOZE: begin
                    declines = up8(declines);
                    if (water_stage != 4'd0 && water_left == 16'd0)
                        water_left = water_snooze;
                    r.close_water = 1'b1;
                end
                prtu_pkg::ACT_STOOD: begin
                    stands   = up8(stands);
                    declines = '0;
                    arm_sit();
                    arm_water(it.temperature);
                    r.close_water = 1'b1;
                    r.close_sit   = 1'b1;
                end
                prtu_pkg::ACT_SIT_SNOOZE: begin
                    declines = up8(declines);
                    if (sit_stage != 4'd0 && sit_left == 16'd0)
                        sit_left = (sit_stage == 4'd1) ? sit_second : sit_later;
                    r.close_sit = 1'b1;
                end
                prtu_pkg::ACT_NEW_DAY: begin
                    drinks   = '0;
                    stands   = '0;
                    declines = '0;
                end
                default: ;
            endcase
            r.seated       = seated;
            r.water_left   = water_left;
            r.sit_left     = sit_left;
            r.drinks_today = drinks;
            r.stands_today = stands;
            r.declines     = declines;
            expected_results.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endtask

        task cmp(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s: got %0d, expected %0d",
                                 results_seen, name, got, want));
        endtask

        task check_result(prtu_pkg::t_result got);
            prtu_pkg::t_result want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding",
                                 results_seen));
                return;
            end
            want = expected_results.pop_front();
            cmp("seated",          16'(got.seated),          16'(want.seated));
            cmp("presence_event",  16'(got.presence_event),  16'(want.presence_event));
            cmp("water_popup",     16'(got.water_popup),     16'(want.water_popup));
            cmp("sit_popup",       16'(got.sit_popup),       16'(want.sit_popup));
            cmp("close_water",     16'(got.close_water),     16'(want.close_water));
            cmp("close_sit",       16'(got.close_sit),       16'(want.close_sit));
            cmp("water_milestone", 16'(got.water_milestone), 16'(want.water_milestone));
            cmp("water_left",      got.water_left,           want.water_left);
            cmp("sit_left",        got.sit_left,             want.sit_left);
            cmp("drinks_today",    16'(got.drinks_today),    16'(want.drinks_today));
            cmp("stands_today",    16'(got.stands_today),    16'(want.stands_today));
            cmp("declines",        16'(got.declines),        16'(want.declines));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    prtu_in_if  in_ch ();
    prtu_out_if out_ch ();
    prtu_cfg_if cfg_ch ();

    presence_reminder_timer_unit #(
        .SEAT_DEBOUNCE (SEAT_TICKS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    reminder_scoreboard sb;

    // Idle percentages for the two sides, and a request for a long receiver
    // hold-off which the ready process counts out on its own.
    int send_idle_pct = 20;
    int recv_idle_pct = 69;
    int hold_cycles   = 0;
    int items_sent    = 0;
    int settings_used = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Generous fixed bound on the whole run; a hung handshake ends up here.
    initial begin
        #4_000_000;
        $display("Simulation timed out with %0d results outstanding.", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver side. Ready is redrawn every cycle from the current idle
    // percentage. When a hold-off is requested, ready is held low for that many
    // cycles while the sender keeps offering, so the block fills and back-pressures.
    initial begin : ready_driver
        int n;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result monitor. Outputs are sampled at the rising edge, before any
    // nonblocking update of that edge lands, so both sides see the same values.
    always @(posedge i_clk) begin : result_watch
        prtu_pkg::t_result got;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.seated          = out_ch.seated;
            got.presence_event  = out_ch.presence_event;
            got.water_popup     = out_ch.water_popup;
            got.sit_popup       = out_ch.sit_popup;
            got.close_water     = out_ch.close_water;
            got.close_sit       = out_ch.close_sit;
            got.water_milestone = out_ch.water_milestone;
            got.water_left      = out_ch.water_left;
            got.sit_left        = out_ch.sit_left;
            got.drinks_today    = out_ch.drinks_today;
            got.stands_today    = out_ch.stands_today;
            got.declines        = out_ch.declines;
            sb.check_result(got);
        end
    end

    // Temperatures are drawn either close to the hot threshold, so that both
    // weather intervals are chosen often, or anywhere in the legal range.
    function automatic logic signed [7:0] rnd_temp();
        int t;
        if ($urandom_range(0, 1) == 1)
            t = int'(sb.hot_level) + int'($urandom_range(0, 4)) - 2;
        else
            t = int'($urandom_range(0, 191)) - 64;
        if (t < -64)
            t = -64;
        if (t > 127)
            t = 127;
        return 8'(t);
    endfunction

    // Presence on a button transaction is ignored, so it is drawn at random.
    function automatic logic [1:0] rnd_pres();
        return 2'($urandom_range(0, 3));
    endfunction

    // Offers one item and waits for its transaction. Valid stays high from one
    // item to the next unless the sender decides to idle first.
    task automatic offer(logic [2:0] act, logic [1:0] pres, logic signed [7:0] temp);
        prtu_pkg::t_item it;
        it.action      = act;
        it.presence    = pres;
        it.temperature = temp;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.presence    <= pres;
        in_ch.temperature <= temp;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(it);
        items_sent++;
    endtask

    // Stops offering and waits, within a bound, until every queued result is in.
    task automatic wait_for_results();
        int n;
        n = 0;
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (sb.pending() > 0 && n < 50000);
    endtask

    task automatic write_reg(prtu_pkg::t_cfg_index idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drains the block, then loads a full register set.
    task automatic load_settings(logic [7:0] absent, logic [15:0] wfirst, logic [15:0] whot,
                                 logic signed [7:0] thr, logic [15:0] wsnooze,
                                 logic [15:0] sfirst, logic [15:0] ssecond,
                                 logic [15:0] slater);
        wait_for_results();
        repeat (4) @(posedge i_clk);
        write_reg(prtu_pkg::CFG_ABSENT_DEBOUNCE, {8'h00, absent});
        write_reg(prtu_pkg::CFG_WATER_FIRST, wfirst);
        write_reg(prtu_pkg::CFG_WATER_HOT, whot);
        write_reg(prtu_pkg::CFG_HOT_THRESHOLD, {8'h00, thr});
        write_reg(prtu_pkg::CFG_WATER_SNOOZE, wsnooze);
        write_reg(prtu_pkg::CFG_SIT_FIRST, sfirst);
        write_reg(prtu_pkg::CFG_SIT_SECOND, ssecond);
        write_reg(prtu_pkg::CFG_SIT_LATER, slater);
        settings_used++;
    endtask

    // Mostly well-formed sessions: sit down, a body of ticks, leaves and
    // buttons, then an absence that usually ends the session. About one pass in
    // eight is a noise item drawn over every code, and some sit-downs fall one
    // tick short so that the debounce is broken.
    task automatic run_sessions(int count);
        int stop;
        int k;
        int body;
        int away_run;
        int r;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(0, 99) < 12) begin
                offer(3'($urandom_range(0, 7)), rnd_pres(), rnd_temp());
            end else begin
                k = $urandom_range(SEAT_TICKS - 1, SEAT_TICKS + 1);
                for (int i = 0; i < k; i++)
                    offer(prtu_pkg::ACT_TICK,
                          ($urandom_range(0, 9) == 0) ? PRES_MISSING : prtu_pkg::PRES_NEAR,
                          rnd_temp());
                body = $urandom_range(4, 40);
                for (int i = 0; i < body; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 55) begin
                        offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, rnd_temp());
                    end else if (r < 63) begin
                        away_run = $urandom_range(1, 4);
                        for (int j = 0; j < away_run; j++)
                            offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_AWAY, rnd_temp());
                    end else if (r < 67) begin
                        offer(prtu_pkg::ACT_TICK,
                              ($urandom_range(0, 1) == 1) ? PRES_MISSING : PRES_CODE3,
                              rnd_temp());
                    end else if (r < 77) begin
                        offer(prtu_pkg::ACT_SIT_SNOOZE, rnd_pres(), rnd_temp());
                    end else if (r < 85) begin
                        offer(prtu_pkg::ACT_WATER_SNOOZE, rnd_pres(), rnd_temp());
                    end else if (r < 91) begin
                        offer(prtu_pkg::ACT_DRANK, rnd_pres(), rnd_temp());
                    end else if (r < 96) begin
                        offer(prtu_pkg::ACT_STOOD, rnd_pres(), rnd_temp());
                    end else if (r < 98) begin
                        offer(prtu_pkg::ACT_NEW_DAY, rnd_pres(), rnd_temp());
                    end else begin
                        offer(($urandom_range(0, 1) == 1) ? ACT_SPARE_6 : ACT_SPARE_7,
                              rnd_pres(), rnd_temp());
                    end
                end
                // Now and then the absence falls short and the session carries on.
                away_run = int'(sb.absent_limit) + int'($urandom_range(0, 2));
                if ($urandom_range(0, 3) == 0)
                    away_run = away_run - 3;
                if (away_run < 1)
                    away_run = 1;
                for (int j = 0; j < away_run; j++)
                    offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_AWAY, rnd_temp());
            end
        end
    endtask

    initial begin : stimulus
        sb = new();
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= prtu_pkg::ACT_TICK;
        in_ch.presence    <= prtu_pkg::PRES_NEAR;
        in_ch.temperature <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= prtu_pkg::CFG_ABSENT_DEBOUNCE;
        cfg_ch.data       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short intervals so that popups, snoozes and session ends come quickly.
        load_settings(8'd3, 16'd7, 16'd4, 8'sd20, 16'd2, 16'd6, 16'd3, 16'd2);

        // Directed part. First the quiet cases: a sit-down broken by an away
        // tick, the spare action codes, snoozes with no popup raised, and the
        // sensor-missing codes while nobody is seated.
        offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, -8'sd64);
        offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, 8'sd0);
        offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_AWAY, 8'sd0);
        offer(ACT_SPARE_6, prtu_pkg::PRES_NEAR, 8'sd0);
        offer(ACT_SPARE_7, PRES_CODE3, 8'sd127);
        offer(prtu_pkg::ACT_WATER_SNOOZE, prtu_pkg::PRES_AWAY, 8'sd5);
        offer(prtu_pkg::ACT_SIT_SNOOZE, PRES_MISSING, 8'sd5);
        offer(prtu_pkg::ACT_TICK, PRES_CODE3, 8'sd0);
        offer(prtu_pkg::ACT_TICK, PRES_MISSING, 8'sd0);
        // Sit down in hot weather, then run both countdowns out. A missing
        // sensor reading in the middle must not stop them.
        repeat (SEAT_TICKS) offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, 8'sd127);
        repeat (3) offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, 8'sd20);
        offer(prtu_pkg::ACT_TICK, PRES_MISSING, 8'sd20);
        offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, 8'sd20);
        // Snooze both raised popups, then leave: the third away tick both
        // records the automatic stand and ends the session.
        offer(prtu_pkg::ACT_SIT_SNOOZE, prtu_pkg::PRES_NEAR, 8'sd20);
        offer(prtu_pkg::ACT_WATER_SNOOZE, prtu_pkg::PRES_NEAR, 8'sd20);
        repeat (3) offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_AWAY, 8'sd19);
        offer(prtu_pkg::ACT_DRANK, prtu_pkg::PRES_NEAR, -8'sd64);
        offer(prtu_pkg::ACT_STOOD, prtu_pkg::PRES_AWAY, 8'sd127);
        offer(prtu_pkg::ACT_NEW_DAY, PRES_CODE3, 8'sd0);
        run_sessions(80);

        // Register values of one and the coldest drawn threshold. Alternating ticks
        // and snoozes push both popup stages to their ceiling.
        load_settings(8'd1, 16'd1, 16'd1, -8'sd64, 16'd1, 16'd1, 16'd1, 16'd1);
        repeat (SEAT_TICKS) offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, rnd_temp());
        repeat (20) begin
            offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, rnd_temp());
            offer(prtu_pkg::ACT_SIT_SNOOZE, rnd_pres(), rnd_temp());
            offer(prtu_pkg::ACT_WATER_SNOOZE, rnd_pres(), rnd_temp());
        end
        // Long receiver hold-off while the sender offers without pause.
        send_idle_pct = 0;
        hold_cycles   = 150;
        run_sessions(40);
        send_idle_pct = 20;
        run_sessions(40);

        // The idle pattern swaps over: the sender now idles far more often.
        send_idle_pct = 69;
        recv_idle_pct = 20;

        // Highest register values. A few short leaves in one session, then a full
        // absence whose away ticks carry the accumulated away time into
        // saturation before the session ends.
        load_settings(8'd255, 16'hFFFF, 16'hFFFF, 8'sd127, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF);
        repeat (SEAT_TICKS) offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, rnd_temp());
        repeat (4) begin
            repeat (3) offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_AWAY, rnd_temp());
            offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_NEAR, rnd_temp());
        end
        repeat (255) offer(prtu_pkg::ACT_TICK, prtu_pkg::PRES_AWAY, rnd_temp());

        // Zero debounce ends a session on its first away tick, and zero
        // intervals leave their countdowns stopped. The hot interval, the water
        // snooze and the second sit interval are not zero. Halfway through, the sender
        // pauses until every outstanding result has come back.
        load_settings(8'd0, 16'd0, 16'd3, 8'sd0, 16'd2, 16'd0, 16'd2, 16'd0);
        run_sessions(30);
        wait_for_results();
        run_sessions(30);

        // Neither side idles from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Back to the reset values, then long button runs that saturate the
        // decline, stand and drink counts, passing the drink milestone on the way.
        load_settings(8'd30, 16'd2700, 16'd1800, 8'sd30, 16'd900, 16'd1800, 16'd3600,
                      16'd5400);
        repeat (260) offer(prtu_pkg::ACT_WATER_SNOOZE, rnd_pres(), rnd_temp());
        repeat (260) offer(prtu_pkg::ACT_STOOD, rnd_pres(), rnd_temp());
        repeat (262) offer(prtu_pkg::ACT_DRANK, rnd_pres(), rnd_temp());
        offer(prtu_pkg::ACT_NEW_DAY, rnd_pres(), rnd_temp());

        // A few random settings with short intervals.
        repeat (3) begin
            load_settings(8'($urandom_range(1, 12)), 16'($urandom_range(1, 30)),
                          16'($urandom_range(1, 30)), 8'(int'($urandom_range(0, 191)) - 64),
                          16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                          16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)));
            run_sessions(30);
        end

        // Let everything drain, then keep watching the output so that any surplus
        // result would still be caught.
        wait_for_results();
        repeat (8) @(posedge i_clk);
        while (sb.pending() > 0) begin
            void'(sb.expected_results.pop_front());
            sb.report("an expected result never arrived");
        end

        $display("Covered %0d items and %0d results over %0d register settings.",
                 items_sent, sb.results_seen, settings_used);
        $display("Included saturation of counts and stages, zero intervals and back-pressure.");
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches found.", sb.mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
